/* hdl/sob_pkg.sv */
// shared types and constants for the sobel edge magnitude block
// no dependencies; used by every module in hdl/
package sob_pkg;

  localparam int PIX_W          = 8;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int IMG_W_W        = 12;
  localparam int IMG_H_W        = 13;
  localparam int WIDTH_RST      = 640;
  localparam int HEIGHT_RST     = 480;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 1;
  localparam int ROW_OUT_W      = 12;
  localparam int COL_OUT_W      = 11;
  localparam int LINE_W         = 2 * PIX_W;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QLVL_W         = $clog2(QDEPTH + 1);
  localparam int SUM_W          = PIX_W + 3;
  localparam int GRAD_W         = SUM_W - 2;
  localparam int SQ_W           = 2 * PIX_W;
  localparam int RAD_W          = SQ_W + 2;
  localparam int ISQ_STEPS      = RAD_W / 2;
  localparam int ROOT_W         = ISQ_STEPS;
  localparam int REM_W          = ROOT_W + 2;
  localparam int EDGE_MAX       = 255;
  localparam int OUT_DATA_W     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } sob_reg_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } sob_meta_t;

  typedef struct packed {
    logic [PIX_W-1:0] p00;
    logic [PIX_W-1:0] p10;
    logic [PIX_W-1:0] p20;
    logic [PIX_W-1:0] p01;
    logic [PIX_W-1:0] p21;
    logic [PIX_W-1:0] p02;
    logic [PIX_W-1:0] p12;
    logic [PIX_W-1:0] p22;
  } sob_win_t;

  typedef struct packed {
    sob_win_t  win;
    sob_meta_t meta;
  } sob_item_t;

  typedef struct packed {
    logic      push;
    sob_item_t item;
  } sob_qwr_t;

endpackage

/* hdl/sob_front.sv */
// front end: position counters, line store memory and 3x3 window
// depends on sob_pkg; pushes full windows into sob_fifo
module sob_front #(
  parameter int MAX_WIDTH  = sob_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sob_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sob_pkg::PIX_W-1:0]    pixel,
  input  logic                         frame_start,
  input  logic [sob_pkg::IMG_W_W-1:0]  image_width,
  input  logic [sob_pkg::IMG_H_W-1:0]  image_height,
  input  logic [sob_pkg::QLVL_W-1:0]   q_level,
  output sob_pkg::sob_qwr_t            qwr
);

  localparam int PIX_W     = sob_pkg::PIX_W;
  localparam int LINE_W    = sob_pkg::LINE_W;
  localparam int QLVL_W    = sob_pkg::QLVL_W;
  localparam int ROW_OUT_W = sob_pkg::ROW_OUT_W;
  localparam int COL_OUT_W = sob_pkg::COL_OUT_W;
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int RW        = $clog2(MAX_HEIGHT);
  localparam int WW        = (CW + 1 > sob_pkg::IMG_W_W) ? CW + 1 : sob_pkg::IMG_W_W;
  localparam int HW        = (RW + 1 > sob_pkg::IMG_H_W) ? RW + 1 : sob_pkg::IMG_H_W;

  logic [CW-1:0]     col;
  logic [RW-1:0]     row;
  logic [CW-1:0]     c;
  logic [RW-1:0]     r;
  logic [WW-1:0]     w_reg;
  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_reg;
  logic [HW-1:0]     h_eff;
  logic              end_row;
  logic              end_frame;
  logic              accept;

  logic              s1_valid;
  logic              s1_emit;
  logic [CW-1:0]     s1_col;
  logic [PIX_W-1:0]  s1_pix;
  sob_pkg::sob_meta_t s1_meta;

  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_q;
  logic [LINE_W-1:0] byp_data;
  logic              byp_hit;
  logic [LINE_W-1:0] rd_fix;
  logic [LINE_W-1:0] wr_data;
  logic [PIX_W-1:0]  upper;
  logic [PIX_W-1:0]  middle;
  logic [PIX_W-1:0]  win [6];

  // effective frame size, clamped to the legal range
  always_comb begin
    w_reg = WW'(image_width);
    h_reg = HW'(image_height);
    if (w_reg < WW'(3)) begin
      w_eff = WW'(3);
    end else if (w_reg > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_reg;
    end
    if (h_reg < HW'(3)) begin
      h_eff = HW'(3);
    end else if (h_reg > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = h_reg;
    end
  end

  always_comb begin
    in_ready  = ({1'b0, q_level} + (QLVL_W + 1)'(s1_valid)) < (QLVL_W + 1)'(sob_pkg::QDEPTH);
    accept    = in_valid && in_ready;
    c         = frame_start ? '0 : col;
    r         = frame_start ? '0 : row;
    end_row   = (WW'(c) + WW'(1)) >= w_eff;
    end_frame = (HW'(r) + HW'(1)) >= h_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else begin
      s1_valid <= accept;
      byp_hit  <= s1_valid && (c == s1_col);
      if (accept) begin
        if (end_row) begin
          col <= '0;
          row <= end_frame ? '0 : r + RW'(1);
        end else begin
          col <= c + CW'(1);
          row <= r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col        <= c;
      s1_pix        <= pixel;
      s1_emit       <= (r >= RW'(2)) && (c >= CW'(2));
      s1_meta.row   <= ROW_OUT_W'(r - RW'(1));
      s1_meta.col   <= COL_OUT_W'(c - CW'(1));
      s1_meta.last  <= (WW'(c) == w_eff - WW'(1)) && (HW'(r) == h_eff - HW'(1));
    end
  end

  // line store: {upper, middle} per column, read registered
  always_comb begin
    rd_fix  = byp_hit ? byp_data : rd_q;
    upper   = rd_fix[LINE_W-1:PIX_W];
    middle  = rd_fix[PIX_W-1:0];
    wr_data = {middle, s1_pix};
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_mem[s1_col] <= wr_data;
    end
    rd_q     <= line_mem[c];
    byp_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_valid) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= upper;
      win[4] <= middle;
      win[5] <= s1_pix;
    end
  end

  always_comb begin
    qwr.push          = s1_valid && s1_emit;
    qwr.item.win.p00  = win[0];
    qwr.item.win.p10  = win[1];
    qwr.item.win.p20  = win[2];
    qwr.item.win.p01  = win[3];
    qwr.item.win.p21  = win[5];
    qwr.item.win.p02  = upper;
    qwr.item.win.p12  = middle;
    qwr.item.win.p22  = s1_pix;
    qwr.item.meta     = s1_meta;
  end

endmodule

/* hdl/sob_fifo.sv */
// short queue of full windows between front and back end
// depends on sob_pkg
module sob_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  sob_pkg::sob_qwr_t          qwr,
  input  logic                       pop,
  output sob_pkg::sob_item_t         head,
  output logic                       not_empty,
  output logic [sob_pkg::QLVL_W-1:0] level
);

  localparam int QPTR_W = sob_pkg::QPTR_W;
  localparam int QLVL_W = sob_pkg::QLVL_W;

  sob_pkg::sob_item_t slots [sob_pkg::QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QLVL_W-1:0]  count;

  always_comb begin
    head      = slots[rd_ptr];
    not_empty = count != '0;
    level     = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (qwr.push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QLVL_W'(qwr.push) - QLVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (qwr.push) begin
      slots[wr_ptr] <= qwr.item;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qwr.push |-> (count < QLVL_W'(sob_pkg::QDEPTH)))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue pop while empty");
  a_level_tracks: assert property (@(posedge clk) disable iff (rst)
    (qwr.push && !pop) |=> (count == $past(count) + QLVL_W'(1)))
    else $error("queue level lost a push");
`endif

endmodule

/* hdl/sob_back.sv */
// back end: sobel sums, squares and pipelined integer square root
// depends on sob_pkg; pops windows from sob_fifo
module sob_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  sob_pkg::sob_item_t            q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sob_pkg::PIX_W-1:0]     edge_value,
  output logic [sob_pkg::ROW_OUT_W-1:0] center_row,
  output logic [sob_pkg::COL_OUT_W-1:0] center_col,
  output logic                          last_of_frame
);

  localparam int PIX_W     = sob_pkg::PIX_W;
  localparam int SUM_W     = sob_pkg::SUM_W;
  localparam int GRAD_W    = sob_pkg::GRAD_W;
  localparam int SQ_W      = sob_pkg::SQ_W;
  localparam int RAD_W     = sob_pkg::RAD_W;
  localparam int ROOT_W    = sob_pkg::ROOT_W;
  localparam int REM_W     = sob_pkg::REM_W;
  localparam int ISQ_STEPS = sob_pkg::ISQ_STEPS;

  logic                      adv;
  sob_pkg::sob_win_t         w;
  logic signed [SUM_W-1:0]   gx;
  logic signed [SUM_W-1:0]   gy;

  logic                      g_valid;
  logic signed [GRAD_W-1:0]  g_x;
  logic signed [GRAD_W-1:0]  g_y;
  sob_pkg::sob_meta_t        g_meta;

  logic signed [2*GRAD_W-1:0] prod_x;
  logic signed [2*GRAD_W-1:0] prod_y;
  logic                      sq_valid;
  logic [SQ_W-1:0]           sq_x;
  logic [SQ_W-1:0]           sq_y;
  sob_pkg::sob_meta_t        sq_meta;

  logic                      vld  [ISQ_STEPS+1];
  logic [RAD_W-1:0]          rad  [ISQ_STEPS+1];
  logic [REM_W-1:0]          rem  [ISQ_STEPS+1];
  logic [ROOT_W-1:0]         root [ISQ_STEPS+1];
  sob_pkg::sob_meta_t        meta [ISQ_STEPS+1];

  always_comb begin
    adv   = !out_valid || out_ready;
    q_pop = adv && q_valid;
    w     = q_item.win;
    gx = $signed((SUM_W'(w.p00) + (SUM_W'(w.p10) << 1) + SUM_W'(w.p20))
               - (SUM_W'(w.p02) + (SUM_W'(w.p12) << 1) + SUM_W'(w.p22)));
    gy = $signed((SUM_W'(w.p20) + (SUM_W'(w.p21) << 1) + SUM_W'(w.p22))
               - (SUM_W'(w.p00) + (SUM_W'(w.p01) << 1) + SUM_W'(w.p02)));
    prod_x = g_x * g_x;
    prod_y = g_y * g_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid   <= 1'b0;
      sq_valid  <= 1'b0;
      vld[0]    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      g_valid   <= q_pop;
      sq_valid  <= g_valid;
      vld[0]    <= sq_valid;
      out_valid <= vld[ISQ_STEPS];
    end
  end

  // floor divide by four is the arithmetic shift
  always_ff @(posedge clk) begin
    if (adv) begin
      g_x     <= gx[SUM_W-1:2];
      g_y     <= gy[SUM_W-1:2];
      g_meta  <= q_item.meta;
      sq_x    <= SQ_W'(prod_x);
      sq_y    <= SQ_W'(prod_y);
      sq_meta <= g_meta;
      rad[0]  <= RAD_W'(sq_x) + RAD_W'(sq_y);
      rem[0]  <= '0;
      root[0] <= '0;
      meta[0] <= sq_meta;
      edge_value    <= (root[ISQ_STEPS] > ROOT_W'(sob_pkg::EDGE_MAX)) ?
                       PIX_W'(sob_pkg::EDGE_MAX) : root[ISQ_STEPS][PIX_W-1:0];
      center_row    <= meta[ISQ_STEPS].row;
      center_col    <= meta[ISQ_STEPS].col;
      last_of_frame <= meta[ISQ_STEPS].last;
    end
  end

  // one root bit per stage, two radicand bits consumed each step
  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
    logic [REM_W+1:0] tmp;
    logic [REM_W+1:0] trial;
    logic             take;

    always_comb begin
      tmp   = {rem[k], rad[k][RAD_W-1-2*k -: 2]};
      trial = (REM_W + 2)'({root[k], 2'b01});
      take  = tmp >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad[k+1]  <= rad[k];
        rem[k+1]  <= take ? REM_W'(tmp - trial) : REM_W'(tmp);
        root[k+1] <= {root[k][ROOT_W-2:0], take};
        meta[k+1] <= meta[k];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(g_valid) && $stable(sq_valid) && $stable(vld[ISQ_STEPS])))
    else $error("pipeline moved during output stall");
  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> g_valid)
    else $error("popped window did not enter the pipeline");
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    vld[ISQ_STEPS] |-> (root[ISQ_STEPS] <= ROOT_W'(361)))
    else $error("square root beyond largest gradient");
`endif

endmodule

/* hdl/sobel_edge_magnitude_3x3_top.sv */
// top level of the 3x3 sobel edge magnitude block: config registers
// depends on sob_pkg, sob_front, sob_fifo and sob_back
//
// Usage:
//   s_* carries grayscale pixels in raster order, one per beat; s_tuser
//   marks the first pixel of a frame and clears the position counters.
//   m_* carries one beat per pixel whose full 3x3 window exists (row and
//   column of the incoming pixel both >= 2); border pixels give no beat.
//   m_tlast marks the last edge value of a frame.
//   cfg_we/cfg_index/cfg_data write image_width (0) and image_height (1);
//   write only while the block is idle.
//   Throughput: one pixel per cycle, sustained, while m_tready is high.
//   An accepted pixel reaches m_tvalid through the line store read,
//   the queue, the sum and square stages, the nine stage square root
//   pipeline and the output register.
//   While m_tvalid is high and m_tready low the back pipeline holds; the four
//   entry queue fills; s_tready drops once it and the front stage hold four.
//   Reset (rst, synchronous) restores 640 x 480, clears the counters,
//   window, queue and pipeline; line store contents are kept unset.
module sobel_edge_magnitude_3x3_top #(
  parameter int MAX_WIDTH  = sob_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sob_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] gray_pixel
  input  logic                           s_tuser,   // [0] frame_start
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sob_pkg::OUT_DATA_W-1:0] m_tdata,   // [7:0] edge_value, [19:8] center_row,
                                                    // [30:20] center_col, [31] zero
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [sob_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sob_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int OUT_USED = sob_pkg::PIX_W + sob_pkg::ROW_OUT_W + sob_pkg::COL_OUT_W;

  logic [sob_pkg::IMG_W_W-1:0]   image_width;
  logic [sob_pkg::IMG_H_W-1:0]   image_height;
  sob_pkg::sob_qwr_t             qwr;
  sob_pkg::sob_item_t            q_head;
  logic                          q_valid;
  logic                          q_pop;
  logic [sob_pkg::QLVL_W-1:0]    q_level;
  logic [sob_pkg::PIX_W-1:0]     edge_value;
  logic [sob_pkg::ROW_OUT_W-1:0] center_row;
  logic [sob_pkg::COL_OUT_W-1:0] center_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sob_pkg::IMG_W_W'(sob_pkg::WIDTH_RST);
      image_height <= sob_pkg::IMG_H_W'(sob_pkg::HEIGHT_RST);
    end else if (cfg_we) begin
      case (sob_pkg::sob_reg_t'(cfg_index))
        sob_pkg::REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[sob_pkg::IMG_W_W-1:0];
        end
        sob_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[sob_pkg::IMG_H_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  sob_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .pixel        (s_tdata),
    .frame_start  (s_tuser),
    .image_width  (image_width),
    .image_height (image_height),
    .q_level      (q_level),
    .qwr          (qwr)
  );

  sob_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .qwr       (qwr),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_valid),
    .level     (q_level)
  );

  sob_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_head),
    .q_pop         (q_pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .edge_value    (edge_value),
    .center_row    (center_row),
    .center_col    (center_col),
    .last_of_frame (m_tlast)
  );

  assign m_tdata = {(sob_pkg::OUT_DATA_W - OUT_USED)'(0), center_col, center_row, edge_value};

endmodule

/* bench/testbench.sv */
// self-checking bench for sobel_edge_magnitude_3x3_top: pixel frames in, edge beats checked
// against a behavioral predictor of the window, line stores and square root
// depends on sob_pkg and the rtl top level
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;
  localparam int TIMEOUT_NS   = 2_000_000;

  typedef struct {
    logic [7:0] pix;
    logic       fs;
  } pixel_beat_t;

  typedef struct {
    logic [7:0]  mag;
    logic [11:0] row;
    logic [10:0] col;
    logic        last;
  } edge_beat_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata = '0;
  logic                           s_tuser = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [sob_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tlast;
  logic                           cfg_we = 1'b0;
  logic [sob_pkg::CFG_IDX_W-1:0]  cfg_index = sob_pkg::REG_IMAGE_WIDTH;
  logic [sob_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pixel_beat_t pending_pixels[$];
  edge_beat_t  expected_edges[$];
  int          error_count = 0;

  logic [11:0] width_reg = 12'(sob_pkg::WIDTH_RST);
  logic [12:0] height_reg = 13'(sob_pkg::HEIGHT_RST);
  logic [7:0]  upper_row [sob_pkg::MAX_WIDTH_DEF];
  logic [7:0]  middle_row [sob_pkg::MAX_WIDTH_DEF];
  int          old_col [3] = '{0, 0, 0};
  int          mid_col [3] = '{0, 0, 0};
  int          col_pos = 0;
  int          row_pos = 0;
  int          prev_width_used = 0;

  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;
  int          tick = 0;
  pixel_beat_t drive_beat;
  edge_beat_t  want;
  logic [7:0]  directed_pix [18];

  sobel_edge_magnitude_3x3_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < 50) $display("mismatch: %s", what);
    error_count++;
  endtask

  task automatic predict_edge(input logic [7:0] pix, input logic fs);
    int w, h, c, r, idx, top, mid, px, gx, gy, energy, mag;
    edge_beat_t res;
    w = clamp_int(width_reg, 3, sob_pkg::MAX_WIDTH_DEF);
    h = clamp_int(height_reg, 3, sob_pkg::MAX_HEIGHT_DEF);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    idx = c % sob_pkg::MAX_WIDTH_DEF;
    top = upper_row[idx];
    mid = middle_row[idx];
    px = pix;
    gx = (old_col[0] + 2 * old_col[1] + old_col[2]) - (top + 2 * mid + px);
    gy = (old_col[2] + 2 * mid_col[2] + px) - (old_col[0] + 2 * mid_col[0] + top);
    upper_row[idx] = middle_row[idx];
    middle_row[idx] = pix;
    old_col = mid_col;
    mid_col = '{top, mid, px};
    if (r >= 2 && c >= 2) begin
      gx = gx >>> 2;
      gy = gy >>> 2;
      energy = gx * gx + gy * gy;
      mag = 0;
      for (int b = 9; b >= 0; b--) begin
        if ((mag + (1 << b)) * (mag + (1 << b)) <= energy) mag += (1 << b);
      end
      res.mag = (mag > sob_pkg::EDGE_MAX) ? 8'(sob_pkg::EDGE_MAX) : 8'(mag);
      res.row = 12'(r - 1);
      res.col = 11'(c - 1);
      res.last = (r == h - 1) && (c == w - 1);
      expected_edges.push_back(res);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic write_reg(input sob_pkg::sob_reg_t idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= sob_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sob_pkg::REG_IMAGE_WIDTH) width_reg = 12'(value);
    else height_reg = 13'(value);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_pixels.size() != 0 || s_tvalid) @(negedge clk);
    while (expected_edges.size() != 0 && guard < 4000) begin
      @(negedge clk);
      guard++;
    end
    if (expected_edges.size() != 0) begin
      report_mismatch($sformatf("%0d edge values never arrived", expected_edges.size()));
      expected_edges.delete();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int wreg, input int hreg, input bit set_w, input bit set_h,
                           input int n_items, input bit clean, input bit hold_mid);
    int w_used, frame_len, in_frame;
    bit fresh;
    logic fs;
    logic [7:0] pix;
    if (set_w) write_reg(sob_pkg::REG_IMAGE_WIDTH, wreg);
    if (set_h) write_reg(sob_pkg::REG_IMAGE_HEIGHT, hreg);
    w_used = clamp_int(width_reg, 3, sob_pkg::MAX_WIDTH_DEF);
    frame_len = w_used * clamp_int(height_reg, 3, sob_pkg::MAX_HEIGHT_DEF);
    // a wider row would read line store entries not yet written, so restart the frame
    fresh = clean || (w_used > prev_width_used);
    prev_width_used = w_used;
    in_frame = 0;
    @(negedge clk);
    for (int k = 0; k < n_items; k++) begin
      if (hold_mid && k == n_items / 2) wait_drained();
      if (k == 0) fs = fresh ? 1'b1 : 1'($urandom_range(0, 1));
      else if (clean) fs = 1'b0;
      else if (in_frame == 0) fs = ($urandom_range(0, 7) != 0);
      else fs = ($urandom_range(0, 49) == 0);
      if (fs) in_frame = 0;
      in_frame = (in_frame + 1) % frame_len;
      if ($urandom_range(0, 3) == 0) pix = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      else pix = 8'($urandom_range(0, 255));
      pending_pixels.push_back('{pix, fs});
    end
    wait_drained();
  endtask

  // pixel driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) predict_edge(s_tdata, s_tuser);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          drive_beat = pending_pixels.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= drive_beat.pix;
          s_tuser <= drive_beat.fs;
          burst_left--;
          if (burst_left <= 0) begin
            case ($urandom_range(0, 3))
              0: begin
                burst_left = $urandom_range(50, 300);
                gap_left = 0;
              end
              default: begin
                burst_left = $urandom_range(1, 24);
                gap_left = $urandom_range(1, 6);
              end
            endcase
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // edge beat monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_edges.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, data 0x%08h", m_tdata));
        end else begin
          want = expected_edges.pop_front();
          if (m_tdata[7:0] !== want.mag)
            report_mismatch($sformatf("edge_value %0d, expected %0d at row %0d col %0d",
                                      m_tdata[7:0], want.mag, want.row, want.col));
          if (m_tdata[19:8] !== want.row)
            report_mismatch($sformatf("center_row %0d, expected %0d", m_tdata[19:8], want.row));
          if (m_tdata[30:20] !== want.col)
            report_mismatch($sformatf("center_col %0d, expected %0d", m_tdata[30:20], want.col));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last_of_frame %0b, expected %0b at row %0d col %0d",
                                      m_tlast, want.last, want.row, want.col));
          if (m_tdata[31] !== 1'b0)
            report_mismatch("tdata padding bit not zero");
        end
      end
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 400);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= (tick % 5 != 0);
        default: m_tready <= (tick % 8 == 0);
      endcase
      tick++;
    end
  end

  initial begin
    int wreg, hreg;
    bit set_w, set_h;
    directed_pix = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd255, 8'd0,
                     8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // saturating frame, then a frame that follows by wrap with small negative sums
    write_reg(sob_pkg::REG_IMAGE_WIDTH, 3);
    write_reg(sob_pkg::REG_IMAGE_HEIGHT, 3);
    prev_width_used = 3;
    @(negedge clk);
    for (int k = 0; k < 18; k++) pending_pixels.push_back('{directed_pix[k], k == 0});
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 5))
        0: wreg = $urandom_range(0, 2);
        5: wreg = $urandom_range(13, 40);
        default: wreg = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 5))
        0: hreg = $urandom_range(0, 2);
        5: hreg = $urandom_range(11, 30);
        default: hreg = $urandom_range(3, 10);
      endcase
      if (ph == 1) begin
        wreg = 0;
        hreg = 0;
      end
      set_w = (ph <= 1) || ($urandom_range(0, 3) != 0);
      set_h = (ph <= 1) || !set_w || ($urandom_range(0, 3) != 0);
      run_phase(wreg, hreg, set_w, set_h, 150, 1'b0, ph == 3);
    end

    // widest row and tallest frame, both through the clamp
    run_phase(4095, 3, 1'b1, 1'b1, 96, 1'b1, 1'b0);
    run_phase(3, 8191, 1'b1, 1'b1, 60, 1'b1, 1'b0);

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("testbench: done, errors");
    $finish;
  end

endmodule

/* sobel_edge_magnitude_3x3_top.f */
hdl/sob_pkg.sv
hdl/sob_front.sv
hdl/sob_fifo.sv
hdl/sob_back.sv
hdl/sobel_edge_magnitude_3x3_top.sv
bench/testbench.sv
